// File: src/dadd_pkg.sv
// Shared types, constants and calendar functions for the date add and difference block.
package dadd_pkg;

	localparam logic [11:0] YearFirst  = 12'd1900;
	localparam logic [11:0] YearLast   = 12'd2100;
	localparam logic [16:0] SerialLast = 17'd73413;
	localparam logic [7:0]  YearOffLast = 8'd200;

	// Reciprocal of 365 scaled by two to the power of RecipShift, rounded up.
	localparam int unsigned RecipShift = 25;
	localparam logic [16:0] Recip365   = 17'd91930;

	localparam logic ActAdd  = 1'b0;
	localparam logic ActDiff = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_DATE = 2'd1,
		ST_RANGE    = 2'd2
	} status_t;

	typedef struct packed {
		logic               action;
		status_t            status;
		logic signed [17:0] diff;
		logic [16:0]        serial;
	} dadd_tag_t;

	// Leap test for a year given as an offset from 1900, valid over 1900 to 2100.
	function automatic logic is_leap(input logic [7:0] yo);
		is_leap = (yo[1:0] == 2'd0) && (yo != 8'd0) && (yo != YearOffLast);
	endfunction

	// Serial of January 1 of the year at offset yo from 1900.
	// The year after 2100 is covered too, since the year estimate can land there.
	function automatic logic [16:0] year_start(input logic [7:0] yo);
		logic [8:0] quads;
		logic [7:0] leaps;
		quads = ({1'b0, yo} + 9'd3) >> 2;
		leaps = quads[7:0] - ((yo != 8'd0) ? 8'd1 : 8'd0)
			- ((yo > YearOffLast) ? 8'd1 : 8'd0);
		year_start = ({9'd0, yo} * 17'd365) + {9'd0, leaps};
	endfunction

	// Days in the whole months before month m of a year.
	function automatic logic [8:0] month_before(input logic [3:0] m, input logic leap);
		logic [8:0] cum;
		case (m)
			4'd1:    cum = 9'd0;
			4'd2:    cum = 9'd31;
			4'd3:    cum = 9'd59;
			4'd4:    cum = 9'd90;
			4'd5:    cum = 9'd120;
			4'd6:    cum = 9'd151;
			4'd7:    cum = 9'd181;
			4'd8:    cum = 9'd212;
			4'd9:    cum = 9'd243;
			4'd10:   cum = 9'd273;
			4'd11:   cum = 9'd304;
			4'd12:   cum = 9'd334;
			default: cum = 9'd0;
		endcase
		month_before = cum + (((m > 4'd2) && leap) ? 9'd1 : 9'd0);
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		case (m)
			4'd2:                    month_len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
			default:                 month_len = 5'd31;
		endcase
	endfunction

endpackage

// File: src/dadd_date_serial.sv
// Checks one calendar date and converts it to its serial day number from 1900-01-01.
module dadd_date_serial (
	input  logic [4:0]  day,
	input  logic [3:0]  month,
	input  logic [11:0] year,
	output logic        ok,
	output logic [16:0] serial
);
	import dadd_pkg::*;

	logic [11:0] yo_full;
	logic [7:0]  yo;
	logic        leap;
	logic        year_ok;
	logic        month_ok;

	assign yo_full  = year - YearFirst;
	assign yo       = yo_full[7:0];
	assign leap     = is_leap(yo);
	assign year_ok  = (year >= YearFirst) && (year <= YearLast);
	assign month_ok = (month >= 4'd1) && (month <= 4'd12);
	assign ok       = year_ok && month_ok && (day >= 5'd1) && (day <= month_len(month, leap));
	assign serial   = year_start(yo) + {8'd0, month_before(month, leap)}
			+ {12'd0, day} - 17'd1;

endmodule

// File: src/dadd_serial_to_date.sv
// Three pipeline stages that turn a serial day number back into a date and drive the output.
module dadd_serial_to_date (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                valid_in,
	input  dadd_pkg::dadd_tag_t tag_in,
	output logic                valid_out,
	output logic [4:0]          result_day,
	output logic [3:0]          result_month,
	output logic [11:0]         result_year,
	output logic signed [17:0]  difference,
	output dadd_pkg::status_t   status
);
	import dadd_pkg::*;

	logic        valid_s3, valid_s4, valid_s5;
	dadd_tag_t   tag_s3, tag_s4;
	logic [7:0]  q_s3;
	logic [7:0]  yo_s4;
	logic [8:0]  doy_s4;
	logic        leap_s4;

	logic [33:0] prod;
	logic [16:0] st;
	logic [16:0] st_prev;
	logic [7:0]  q_prev;
	logic [16:0] doy_cur;
	logic [16:0] doy_prev;

	logic [3:0]  mon;
	logic [8:0]  cum_sel;
	logic [8:0]  day_idx;
	logic        produce;

	assign prod = {17'd0, tag_in.serial} * {17'd0, Recip365};

	assign q_prev   = q_s3 - 8'd1;
	assign st       = year_start(q_s3);
	assign st_prev  = st - (is_leap(q_prev) ? 17'd366 : 17'd365);
	assign doy_cur  = tag_s3.serial - st;
	assign doy_prev = tag_s3.serial - st_prev;

	always_comb begin
		mon     = 4'd1;
		cum_sel = 9'd0;
		for (int i = 2; i <= 12; i++) begin
			if (month_before(4'(i), leap_s4) <= doy_s4) begin
				mon     = 4'(i);
				cum_sel = month_before(4'(i), leap_s4);
			end
		end
		day_idx = doy_s4 - cum_sel + 9'd1;
		produce = (tag_s4.action == ActAdd) && (tag_s4.status == ST_OK);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_in;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s3 <= tag_in;
			q_s3   <= prod[RecipShift +: 8];

			tag_s4 <= tag_s3;
			if (tag_s3.serial < st) begin
				yo_s4   <= q_prev;
				doy_s4  <= doy_prev[8:0];
				leap_s4 <= is_leap(q_prev);
			end else begin
				yo_s4   <= q_s3;
				doy_s4  <= doy_cur[8:0];
				leap_s4 <= is_leap(q_s3);
			end

			result_day   <= produce ? day_idx[4:0] : 5'd0;
			result_month <= produce ? mon : 4'd0;
			result_year  <= produce ? (YearFirst + {4'd0, yo_s4}) : 12'd0;
			difference   <= tag_s4.diff;
			status       <= tag_s4.status;
		end
	end

	assign valid_out = valid_s5;

endmodule

// File: src/date_add_days_and_difference.sv
// Top level of the Gregorian date add and difference pipeline.
//
// Channel   Direction  Handshake                   Payload
// s_axis    in         tvalid/tready               tdata: dates and offset, tuser: action
// m_axis    out        tvalid/tready               tdata: result date and difference,
//                                                  tuser: status
//
// Each transfer passes five register stages, s1 to s5, on its way to the output.
// A new transfer can be accepted every cycle while the output is free or being taken.
// The whole pipeline freezes while a result waits at the output, so nothing is lost.
// Reset clears all valid bits; payload registers are not reset.
module date_add_days_and_difference (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// base_day, base_month, base_year, second_day, second_month, second_year, offset.
	input  logic [63:0] s_axis_tdata,
	// action.
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// result_day, result_month, result_year, difference.
	output logic [39:0] m_axis_tdata,
	// status.
	output logic [1:0]  m_axis_tuser
);
	import dadd_pkg::*;

	logic        adv;
	logic        ok_a, ok_b;
	logic [16:0] ser_a, ser_b;

	logic               valid_s1, valid_s2;
	logic               action_s1;
	logic               ok_a_s1, ok_b_s1;
	logic [16:0]        ser_a_s1, ser_b_s1;
	logic signed [17:0] off_s1;
	dadd_tag_t          tag_s2;

	logic signed [18:0] sum;
	logic signed [17:0] dif;
	dadd_tag_t          tag_next;

	logic [4:0]         result_day;
	logic [3:0]         result_month;
	logic [11:0]        result_year;
	logic signed [17:0] difference;
	status_t            status;

	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	dadd_date_serial u_base (
		.day    (s_axis_tdata[4:0]),
		.month  (s_axis_tdata[8:5]),
		.year   (s_axis_tdata[20:9]),
		.ok     (ok_a),
		.serial (ser_a)
	);

	dadd_date_serial u_second (
		.day    (s_axis_tdata[25:21]),
		.month  (s_axis_tdata[29:26]),
		.year   (s_axis_tdata[41:30]),
		.ok     (ok_b),
		.serial (ser_b)
	);

	assign sum = $signed({2'b00, ser_a_s1}) + {off_s1[17], off_s1};
	assign dif = $signed({1'b0, ser_b_s1}) - $signed({1'b0, ser_a_s1});

	always_comb begin
		tag_next.action = action_s1;
		tag_next.status = ST_OK;
		tag_next.diff   = '0;
		tag_next.serial = sum[16:0];
		if (action_s1 == ActDiff) begin
			if (!(ok_a_s1 && ok_b_s1)) begin
				tag_next.status = ST_BAD_DATE;
			end else begin
				tag_next.diff = dif;
			end
		end else begin
			if (!ok_a_s1) begin
				tag_next.status = ST_BAD_DATE;
			end else if (sum < 0 || sum > $signed({2'b00, SerialLast})) begin
				tag_next.status = ST_RANGE;
			end
		end
		if (tag_next.status != ST_OK) begin
			tag_next.serial = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_axis_tvalid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			action_s1 <= s_axis_tuser;
			ok_a_s1   <= ok_a;
			ok_b_s1   <= ok_b;
			ser_a_s1  <= ser_a;
			ser_b_s1  <= ser_b;
			off_s1    <= s_axis_tdata[59:42];
			tag_s2    <= tag_next;
		end
	end

	dadd_serial_to_date u_to_date (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (adv),
		.valid_in     (valid_s2),
		.tag_in       (tag_s2),
		.valid_out    (m_axis_tvalid),
		.result_day   (result_day),
		.result_month (result_month),
		.result_year  (result_year),
		.difference   (difference),
		.status       (status)
	);

	assign m_axis_tdata = {1'b0, difference, result_year, result_month, result_day};
	assign m_axis_tuser = status;

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata == 40'd0))
		else $error("failed result carries nonzero fields");

	a_date_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == ST_OK) && (result_year != 12'd0) |->
		(result_month >= 4'd1) && (result_month <= 4'd12) && (result_day >= 5'd1)
		&& (difference == 18'sd0))
		else $error("produced date has a bad month or day");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(ser_a_s1))
		else $error("first stage lost an item during a stall");

endmodule
